@@ src/rtp_pcm_depacketizer_top_defines.svh @@
// Assertion macros used by the depacketizer port checker.
`ifndef RTP_PCM_DEPACKETIZER_TOP_DEFINES_SVH
`define RTP_PCM_DEPACKETIZER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is active.
`define RPD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rpd port check failed");

// Next-cycle implication, disabled while reset is active.
`define RPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rpd port check failed");

`endif

@@ src/rpd_pkg.sv @@
// Types and constants of the RTP PCM depacketizer.
`timescale 1ns / 1ps

package rpd_pkg;

  localparam int SMP_W = 24;

  // Header layout
  localparam logic [3:0] HDR_BYTES      = 4'd12;
  localparam logic [3:0] HDR_POS_PT     = 4'd1;
  localparam logic [3:0] HDR_POS_SEQ_HI = 4'd2;
  localparam logic [3:0] HDR_POS_SEQ_LO = 4'd3;

  // Register indexes
  localparam logic [1:0] REG_CHANNEL_COUNT = 2'd0;
  localparam logic [1:0] REG_PT_24BIT      = 2'd1;
  localparam logic [1:0] REG_PT_16BIT      = 2'd2;

  // Register reset values
  localparam logic [3:0] RST_CHANNEL_COUNT = 4'd1;
  localparam logic [6:0] RST_PT_24BIT      = 7'd97;
  localparam logic [6:0] RST_PT_16BIT      = 7'd96;

  // Packet status codes
  localparam logic [1:0] ST_ACCEPTED = 2'd0;
  localparam logic [1:0] ST_SHORT    = 2'd1;
  localparam logic [1:0] ST_UNKNOWN  = 2'd2;

  // Result kinds
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [15:0] SEQ_HALF = 16'h8000;

  // Per-job info handed from the parser to the emitter
  typedef struct packed {
    logic        has_status;
    logic [1:0]  status;
    logic [15:0] seq;
    logic [31:0] rx_total;
    logic [31:0] drop_total;
    logic [31:0] err_total;
  } job_t;

  // One result item, without kind and run marker
  typedef struct packed {
    logic [31:0]      err_total;
    logic [31:0]      drop_total;
    logic [31:0]      rx_total;
    logic [15:0]      seq;
    logic [1:0]       status;
    logic             frame_end;
    logic [2:0]       channel;
    logic [SMP_W-1:0] sample;
  } res_t;

endpackage

@@ src/rtp_pcm_depacketizer_top.sv @@
// Top level of the RTP L24/L16 PCM depacketizer.
//
//  channel | dir | handshake           | payload
//  in_     | in  | in_tvalid/in_tready | tdata packet byte, tlast end of packet
//  out_    | out | out_tvalid/out_tready | tdata result fields, tuser kind, tlast run end
//  cfg_    | in  | cfg_valid/cfg_ready | cfg_addr register index, cfg_data value
//
// One byte is taken per cycle unless the input register is held. A byte's job goes from
// the input register to the result register; its results go out one per cycle while
// out_tready is high. A byte that completes a frame or ends a packet waits in the input
// register while the previous frame/status job is still draining; throughput is set by
// that one job slot. Reset (rst_n low, synchronous) clears counters, packet state and
// config to defaults. cfg_ready is always high.
`timescale 1ns / 1ps

module rtp_pcm_depacketizer_top #(
  parameter int MAX_CHANNELS = 8,
  parameter int MAX_SAMPLES  = 1024
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,    // [7:0] packet_byte
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [23:0] audio_sample, [26:24] channel_index, [27] frame_end, [29:28] packet_status,
  // [45:30] seq_number, [77:46] received_count, [109:78] dropped_count,
  // [141:110] seq_error_count, [143:142] zero
  output logic [143:0] out_tdata,
  output logic         out_tuser,   // [0] result_kind
  output logic         out_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_addr,
  input  logic [7:0]   cfg_data
);

  localparam int FILL_W = $clog2(MAX_CHANNELS + 1);

  logic                                        job_load, job_free;
  rpd_pkg::job_t                               job_info;
  logic [FILL_W-1:0]                           job_nsamp;
  logic [MAX_CHANNELS-1:0][rpd_pkg::SMP_W-1:0] job_frame;
  rpd_pkg::res_t                               res;

  assign cfg_ready = 1'b1;

  rpd_parser #(
    .MAX_CHANNELS(MAX_CHANNELS),
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_byte   (in_tdata),
    .in_eop    (in_tlast),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_addr),
    .cfg_data  (cfg_data),
    .job_free  (job_free),
    .job_load  (job_load),
    .job_info  (job_info),
    .job_nsamp (job_nsamp),
    .job_frame (job_frame)
  );

  rpd_emitter #(
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_emitter (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_load  (job_load),
    .job_info  (job_info),
    .job_nsamp (job_nsamp),
    .job_frame (job_frame),
    .job_free  (job_free),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_kind  (out_tuser),
    .out_res   (res),
    .out_last  (out_tlast)
  );

  assign out_tdata = {2'b00, res};

endmodule

@@ src/rpd_parser.sv @@
// Input register, header parse, sequence check, sample assembly and frame collection.
`timescale 1ns / 1ps

module rpd_parser #(
  parameter  int MAX_CHANNELS = 8,
  parameter  int MAX_SAMPLES  = 1024,
  localparam int FILL_W  = $clog2(MAX_CHANNELS + 1),
  localparam int TAKEN_W = $clog2(MAX_SAMPLES + 1)
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_valid,
  output logic                                      in_ready,
  input  logic [7:0]                                in_byte,
  input  logic                                      in_eop,
  input  logic                                      cfg_valid,
  input  logic [1:0]                                cfg_index,
  input  logic [7:0]                                cfg_data,
  input  logic                                      job_free,
  output logic                                      job_load,
  output rpd_pkg::job_t                             job_info,
  output logic [FILL_W-1:0]                         job_nsamp,
  output logic [MAX_CHANNELS-1:0][rpd_pkg::SMP_W-1:0] job_frame
);

  localparam int CMP_W = 8;

  // config
  logic [3:0] chan_cnt_r;
  logic [6:0] pt24_r, pt16_r;

  // input register
  logic       hold_valid_r;
  logic [7:0] hold_byte_r;
  logic       hold_eop_r;

  // packet state
  logic [3:0]         hp_r, hp_nxt;
  logic [7:0]         shb_r, shb_nxt;
  logic [6:0]         pk_r, pk_nxt;
  logic [15:0]        asm_r, asm_nxt;
  logic [1:0]         bis_r, bis_nxt;
  logic [TAKEN_W-1:0] taken_r, taken_nxt;
  logic [FILL_W-1:0]  fill_r, fill_nxt;
  logic [15:0]        prev_r, prev_nxt;
  logic               prev_ok_r, prev_ok_nxt;
  logic [31:0]        rx_r, rx_nxt, drop_r, drop_nxt, err_r, err_nxt;
  logic [MAX_CHANNELS-1:0][rpd_pkg::SMP_W-1:0] store_r, store_nxt;

  logic                     frame_done;
  logic                     hold_adv;
  logic                     is24, is16, known;
  logic [CMP_W-1:0]         cc8, max8, ch8;
  logic [15:0]              seq_d;
  logic [rpd_pkg::SMP_W-1:0] smp;
  logic [1:0]               st;
  logic [15:0]              st_seq;

  assign is24  = (pk_r == pt24_r);
  assign is16  = !is24 && (pk_r == pt16_r);
  assign known = is24 || is16;

  assign cc8  = CMP_W'(chan_cnt_r);
  assign max8 = CMP_W'(MAX_CHANNELS);
  assign ch8  = (cc8 == '0) ? CMP_W'(1) : ((cc8 > max8) ? max8 : cc8);

  assign seq_d = asm_r - prev_r;

  always_comb begin
    hp_nxt      = hp_r;
    shb_nxt     = shb_r;
    pk_nxt      = pk_r;
    asm_nxt     = asm_r;
    bis_nxt     = bis_r;
    taken_nxt   = taken_r;
    fill_nxt    = fill_r;
    prev_nxt    = prev_r;
    prev_ok_nxt = prev_ok_r;
    rx_nxt      = rx_r;
    drop_nxt    = drop_r;
    err_nxt     = err_r;
    store_nxt   = store_r;
    frame_done  = 1'b0;
    job_nsamp   = '0;
    smp         = '0;
    st          = rpd_pkg::ST_ACCEPTED;
    st_seq      = '0;

    if (hp_r < rpd_pkg::HDR_BYTES) begin
      if (hp_r == rpd_pkg::HDR_POS_PT) pk_nxt = hold_byte_r[6:0];
      else if (hp_r == rpd_pkg::HDR_POS_SEQ_HI) shb_nxt = hold_byte_r;
      else if (hp_r == rpd_pkg::HDR_POS_SEQ_LO) asm_nxt = {shb_r, hold_byte_r};
      hp_nxt = hp_r + 4'd1;
      // header complete: sequence check on the assembled number
      if (hp_nxt == rpd_pkg::HDR_BYTES) begin
        if (prev_ok_r && seq_d != 16'd1) begin
          err_nxt = err_r + 32'd1;
          if (seq_d != '0 && seq_d < rpd_pkg::SEQ_HALF) begin
            drop_nxt = drop_r + {16'd0, seq_d - 16'd1};
          end else if (seq_d == rpd_pkg::SEQ_HALF && asm_r > prev_r) begin
            drop_nxt = drop_r + {16'd0, rpd_pkg::SEQ_HALF - 16'd1};
          end
        end
        prev_nxt    = asm_r;
        prev_ok_nxt = 1'b1;
        rx_nxt      = rx_r + 32'd1;
        asm_nxt     = '0;
      end
    end else if (known) begin
      if ((is24 && bis_r < 2'd2) || (is16 && bis_r < 2'd1)) begin
        asm_nxt = {asm_r[7:0], hold_byte_r};
        bis_nxt = bis_r + 2'd1;
      end else begin
        smp     = is24 ? {asm_r, hold_byte_r} : {asm_r[7:0], hold_byte_r, 8'd0};
        asm_nxt = '0;
        bis_nxt = '0;
        if (taken_r < TAKEN_W'(MAX_SAMPLES)) begin
          taken_nxt = taken_r + TAKEN_W'(1);
          for (int i = 0; i < MAX_CHANNELS; i++) begin
            if (FILL_W'(i) == fill_r) store_nxt[i] = smp;
          end
          if (CMP_W'(fill_r) + CMP_W'(1) >= ch8) begin
            frame_done = 1'b1;
            job_nsamp  = fill_r + FILL_W'(1);
            fill_nxt   = '0;
          end else begin
            fill_nxt = fill_r + FILL_W'(1);
          end
        end
      end
    end

    if (hold_eop_r) begin
      if (hp_nxt < rpd_pkg::HDR_BYTES) begin
        st = rpd_pkg::ST_SHORT;
      end else begin
        st     = ((pk_nxt == pt24_r) || (pk_nxt == pt16_r)) ? rpd_pkg::ST_ACCEPTED
                                                            : rpd_pkg::ST_UNKNOWN;
        st_seq = prev_nxt;
      end
      hp_nxt    = '0;
      shb_nxt   = '0;
      pk_nxt    = '0;
      asm_nxt   = '0;
      bis_nxt   = '0;
      taken_nxt = '0;
      fill_nxt  = '0;
    end
  end

  // a byte that causes results waits until the emitter can take its job
  assign hold_adv = hold_valid_r && (!(frame_done || hold_eop_r) || job_free);
  assign in_ready = !hold_valid_r || hold_adv;
  assign job_load = hold_adv && (frame_done || hold_eop_r);
  assign job_frame = store_nxt;

  always_comb begin
    job_info.has_status = hold_eop_r;
    job_info.status     = st;
    job_info.seq        = st_seq;
    job_info.rx_total   = rx_nxt;
    job_info.drop_total = drop_nxt;
    job_info.err_total  = err_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_cnt_r <= rpd_pkg::RST_CHANNEL_COUNT;
      pt24_r     <= rpd_pkg::RST_PT_24BIT;
      pt16_r     <= rpd_pkg::RST_PT_16BIT;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rpd_pkg::REG_CHANNEL_COUNT: chan_cnt_r <= cfg_data[3:0];
        rpd_pkg::REG_PT_24BIT:      pt24_r     <= cfg_data[6:0];
        rpd_pkg::REG_PT_16BIT:      pt16_r     <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      hold_valid_r <= 1'b1;
    end else if (hold_adv) begin
      hold_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_byte_r <= in_byte;
      hold_eop_r  <= in_eop;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hp_r      <= '0;
      shb_r     <= '0;
      pk_r      <= '0;
      asm_r     <= '0;
      bis_r     <= '0;
      taken_r   <= '0;
      fill_r    <= '0;
      prev_r    <= '0;
      prev_ok_r <= 1'b0;
      rx_r      <= '0;
      drop_r    <= '0;
      err_r     <= '0;
    end else if (hold_adv) begin
      hp_r      <= hp_nxt;
      shb_r     <= shb_nxt;
      pk_r      <= pk_nxt;
      asm_r     <= asm_nxt;
      bis_r     <= bis_nxt;
      taken_r   <= taken_nxt;
      fill_r    <= fill_nxt;
      prev_r    <= prev_nxt;
      prev_ok_r <= prev_ok_nxt;
      rx_r      <= rx_nxt;
      drop_r    <= drop_nxt;
      err_r     <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (hold_adv) store_r <= store_nxt;
  end

endmodule

@@ src/rpd_emitter.sv @@
// Result register: one job (frame samples and/or status), sent one result per cycle on out_ready.
`timescale 1ns / 1ps

module rpd_emitter #(
  parameter  int MAX_CHANNELS = 8,
  localparam int FILL_W = $clog2(MAX_CHANNELS + 1),
  localparam int IDX_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        job_load,
  input  rpd_pkg::job_t                               job_info,
  input  logic [FILL_W-1:0]                           job_nsamp,
  input  logic [MAX_CHANNELS-1:0][rpd_pkg::SMP_W-1:0] job_frame,
  output logic                                        job_free,
  output logic                                        out_valid,
  input  logic                                        out_ready,
  output logic                                        out_kind,
  output rpd_pkg::res_t                               out_res,
  output logic                                        out_last
);

  logic                job_valid_r;
  logic [FILL_W-1:0]   idx_r, nsamp_r, idx_inc;
  rpd_pkg::job_t       info_r;
  logic [MAX_CHANNELS-1:0][rpd_pkg::SMP_W-1:0] frame_r;
  logic                is_sample;
  logic [IDX_W+2:0]    chan_ext;
  logic                xfer;

  assign idx_inc   = idx_r + FILL_W'(1);
  assign is_sample = (idx_r < nsamp_r);
  // status, when present, follows the last sample
  assign out_last  = info_r.has_status ? (idx_r == nsamp_r) : (idx_inc == nsamp_r);
  assign out_valid = job_valid_r;
  assign xfer      = job_valid_r && out_ready;
  assign job_free  = !job_valid_r || (xfer && out_last);
  assign chan_ext  = {3'd0, idx_r[IDX_W-1:0]};

  always_comb begin
    out_kind           = is_sample ? rpd_pkg::KIND_SAMPLE : rpd_pkg::KIND_STATUS;
    out_res.sample     = is_sample ? frame_r[idx_r[IDX_W-1:0]] : '0;
    out_res.channel    = is_sample ? chan_ext[2:0] : 3'd0;
    out_res.frame_end  = is_sample && (idx_inc == nsamp_r);
    out_res.status     = is_sample ? rpd_pkg::ST_ACCEPTED : info_r.status;
    out_res.seq        = is_sample ? 16'd0 : info_r.seq;
    out_res.rx_total   = info_r.rx_total;
    out_res.drop_total = info_r.drop_total;
    out_res.err_total  = info_r.err_total;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
      idx_r       <= '0;
    end else if (job_load) begin
      job_valid_r <= 1'b1;
      idx_r       <= '0;
    end else if (xfer) begin
      if (out_last) job_valid_r <= 1'b0;
      idx_r <= idx_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (job_load) begin
      info_r  <= job_info;
      nsamp_r <= job_nsamp;
      frame_r <= job_frame;
    end
  end

endmodule

@@ src/rpd_port_checker.sv @@
// Port-level checker for the depacketizer result channel, bound to the top level.
`timescale 1ns / 1ps
`include "rtp_pcm_depacketizer_top_defines.svh"

module rpd_port_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [143:0] out_tdata,
  input logic         out_tuser,
  input logic         out_tlast
);

  logic         stalled;
  logic         status_beat;
  logic         sample_beat;
  logic [145:0] beat;

  assign stalled     = out_tvalid && !out_tready;
  assign status_beat = out_tvalid && (out_tuser == rpd_pkg::KIND_STATUS);
  assign sample_beat = out_tvalid && (out_tuser == rpd_pkg::KIND_SAMPLE);
  assign beat        = {out_tdata, out_tuser, out_tlast};

  // a stalled result holds
  `RPD_ASSERT_NEXT(a_out_hold, clk, rst_n, stalled, out_tvalid && $stable(beat))

  // a status result always closes the run of its byte
  `RPD_ASSERT_IMPL(a_status_last, clk, rst_n, status_beat, out_tlast)

  // status results carry no sample, channel or frame end
  `RPD_ASSERT_IMPL(a_status_clean, clk, rst_n, status_beat, out_tdata[27:0] == 28'd0)

  // sample results carry no status code or sequence number
  `RPD_ASSERT_IMPL(a_sample_clean, clk, rst_n, sample_beat, out_tdata[45:28] == 18'd0)

endmodule

bind rtp_pcm_depacketizer_top rpd_port_checker u_port_checker (.*);

@@ tb/rtp_pcm_depacketizer_top_test.sv @@
// Self-checking testbench for the RTP L24/L16 PCM depacketizer top level.
`timescale 1ns / 1ps

module rtp_pcm_depacketizer_top_test;
  import rpd_pkg::*;

  localparam int FRAME_MAX     = 8;
  localparam int SAMPLE_CAP    = 1024;
  localparam int SETTLE_CYCLES = 6;
  localparam int LONG_HOLD     = 300;
  localparam int RANDOM_BYTES  = 60;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int PRINT_LIMIT   = 40;

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_COIN,
    READY_MOSTLY,
    READY_PATTERN
  } ready_mode_t;

  typedef struct packed {
    logic        kind;
    logic [23:0] sample;
    logic [2:0]  channel;
    logic        frame_end;
    logic [1:0]  status;
    logic [15:0] seq;
    logic [31:0] rx_total;
    logic [31:0] drop_total;
    logic [31:0] err_total;
    logic        last;
  } depkt_result_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic [7:0]   in_tdata = 8'h00;
  logic         in_tlast = 1'b0;
  logic         out_tready = 1'b0;
  logic         cfg_valid = 1'b0;
  logic [1:0]   cfg_addr = REG_CHANNEL_COUNT;
  logic [7:0]   cfg_data = 8'h00;
  logic         in_tready;
  logic         out_tvalid;
  logic [143:0] out_tdata;
  logic         out_tuser;
  logic         out_tlast;
  logic         cfg_ready;

  rtp_pcm_depacketizer_top #(
    .MAX_CHANNELS(FRAME_MAX),
    .MAX_SAMPLES (SAMPLE_CAP)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor copy of registers and packet state
  logic [3:0]    cfg_channels;
  logic [6:0]    cfg_pt24;
  logic [6:0]    cfg_pt16;
  logic [3:0]    hdr_pos;
  logic [7:0]    seq_hi;
  logic [6:0]    pt_held;
  logic [15:0]   last_seq;
  logic          last_seq_valid;
  logic [15:0]   assembly;
  logic [1:0]    byte_pos;
  logic [10:0]   taken;
  logic [23:0]   frame_buf [FRAME_MAX];
  logic [3:0]    fill;
  logic [31:0]   rx_total;
  logic [31:0]   drop_total;
  logic [31:0]   err_total;
  depkt_result_t results_due[$];

  // Stimulus bookkeeping
  logic [7:0]    payload_bytes[$];
  logic [15:0]   seq_next = 16'h1234;
  int            burst_left = 0;
  logic          gaps_on = 1'b1;
  logic          hold_req = 1'b0;
  logic          hold_taken = 1'b0;
  int            bytes_sent = 0;
  int            packets_sent = 0;
  int            results_checked = 0;
  int            cfg_writes = 0;
  int            error_count = 0;
  int            cycle_count = 0;

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= PRINT_LIMIT)
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %h want %h", name, got, want));
  endtask

  function automatic logic [3:0] frame_size();
    if (cfg_channels == 4'd0) return 4'd1;
    if (cfg_channels > FRAME_MAX) return 4'(FRAME_MAX);
    return cfg_channels;
  endfunction

  task automatic clear_packet_state();
    hdr_pos  = 4'd0;
    seq_hi   = 8'h00;
    pt_held  = 7'd0;
    assembly = 16'h0000;
    byte_pos = 2'd0;
    taken    = 11'd0;
    fill     = 4'd0;
  endtask

  task automatic reset_predictor();
    cfg_channels   = RST_CHANNEL_COUNT;
    cfg_pt24       = RST_PT_24BIT;
    cfg_pt16       = RST_PT_16BIT;
    last_seq       = 16'h0000;
    last_seq_valid = 1'b0;
    rx_total       = 32'd0;
    drop_total     = 32'd0;
    err_total      = 32'd0;
    clear_packet_state();
  endtask

  task automatic apply_config(input logic [1:0] idx, input logic [7:0] value);
    case (idx)
      REG_CHANNEL_COUNT: cfg_channels = value[3:0];
      REG_PT_24BIT:      cfg_pt24 = value[6:0];
      REG_PT_16BIT:      cfg_pt16 = value[6:0];
      default: ;
    endcase
  endtask

  task automatic account_sequence(input logic [15:0] seq);
    logic [15:0] step;
    if (last_seq_valid) begin
      step = seq - last_seq;
      if (step != 16'd1) begin
        err_total++;
        if (step != 16'd0 && step < SEQ_HALF)
          drop_total += 32'(step) - 32'd1;
        else if (step == SEQ_HALF && seq > last_seq)
          drop_total += 32'(SEQ_HALF) - 32'd1;
      end
    end
    last_seq       = seq;
    last_seq_valid = 1'b1;
    rx_total++;
  endtask

  task automatic push_result(input logic kind, input logic [23:0] smp,
                             input logic [2:0] ch, input logic fend,
                             input logic [1:0] st, input logic [15:0] seq);
    depkt_result_t r;
    r.kind       = kind;
    r.sample     = smp;
    r.channel    = ch;
    r.frame_end  = fend;
    r.status     = st;
    r.seq        = seq;
    r.rx_total   = rx_total;
    r.drop_total = drop_total;
    r.err_total  = err_total;
    r.last       = 1'b0;
    results_due.push_back(r);
  endtask

  // Works out every result one accepted byte causes.
  task automatic depacketize_byte(input logic [7:0] b, input logic eop);
    logic [3:0]    nch;
    logic [23:0]   smp;
    int            width;
    int            produced;
    depkt_result_t tail;
    nch      = frame_size();
    produced = 0;
    if (hdr_pos < HDR_BYTES) begin
      if (hdr_pos == HDR_POS_PT) pt_held = b[6:0];
      else if (hdr_pos == HDR_POS_SEQ_HI) seq_hi = b;
      else if (hdr_pos == HDR_POS_SEQ_LO) assembly = {seq_hi, b};
      hdr_pos++;
      if (hdr_pos == HDR_BYTES) begin
        account_sequence(assembly);
        assembly = 16'h0000;
      end
    end else begin
      width = 0;
      if (pt_held == cfg_pt24) width = 3;
      else if (pt_held == cfg_pt16) width = 2;
      if (width != 0) begin
        if (int'(byte_pos) + 1 < width) begin
          assembly = {assembly[7:0], b};
          byte_pos++;
        end else begin
          smp = (width == 3) ? {assembly, b} : {assembly[7:0], b, 8'h00};
          assembly = 16'h0000;
          byte_pos = 2'd0;
          if (taken < SAMPLE_CAP) begin
            taken++;
            if (fill < FRAME_MAX) frame_buf[fill[2:0]] = smp;
            fill++;
            if (fill >= nch) begin
              for (int i = 0; i < int'(fill) && i < FRAME_MAX; i++) begin
                push_result(KIND_SAMPLE, frame_buf[i], 3'(i), (i + 1 == int'(fill)),
                            ST_ACCEPTED, 16'h0000);
                produced++;
              end
              fill = 4'd0;
            end
          end
        end
      end
    end
    if (eop) begin
      if (hdr_pos < HDR_BYTES)
        push_result(KIND_STATUS, 24'h0, 3'd0, 1'b0, ST_SHORT, 16'h0000);
      else if (pt_held == cfg_pt24 || pt_held == cfg_pt16)
        push_result(KIND_STATUS, 24'h0, 3'd0, 1'b0, ST_ACCEPTED, last_seq);
      else
        push_result(KIND_STATUS, 24'h0, 3'd0, 1'b0, ST_UNKNOWN, last_seq);
      produced++;
      clear_packet_state();
    end
    if (produced > 0) begin
      tail = results_due.pop_back();
      tail.last = 1'b1;
      results_due.push_back(tail);
    end
  endtask

  // Result checker
  depkt_result_t head;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (results_due.size() == 0) begin
        report_mismatch("result transfer with nothing pending");
      end else begin
        head = results_due.pop_front();
        results_checked++;
        check_field("result_kind", 32'(out_tuser), 32'(head.kind));
        check_field("audio_sample", 32'(out_tdata[23:0]), 32'(head.sample));
        check_field("channel_index", 32'(out_tdata[26:24]), 32'(head.channel));
        check_field("frame_end", 32'(out_tdata[27]), 32'(head.frame_end));
        check_field("packet_status", 32'(out_tdata[29:28]), 32'(head.status));
        check_field("seq_number", 32'(out_tdata[45:30]), 32'(head.seq));
        check_field("received_count", out_tdata[77:46], head.rx_total);
        check_field("dropped_count", out_tdata[109:78], head.drop_total);
        check_field("seq_error_count", out_tdata[141:110], head.err_total);
        check_field("pad_bits", 32'(out_tdata[143:142]), 32'd0);
        check_field("run_last", 32'(out_tlast), 32'(head.last));
      end
    end
  end

  // Receiver: stall pattern changes every so often; a requested hold overrides it.
  ready_mode_t ready_mode = READY_ALWAYS;
  int          mode_left = 0;
  int          hold_left = 0;
  logic [15:0] ready_pattern = 16'hFFFF;

  always @(negedge clk) begin
    if (hold_req && !hold_taken) begin
      hold_left  = LONG_HOLD;
      hold_taken = 1'b1;
    end else if (!hold_req) begin
      hold_taken = 1'b0;
    end
    if (mode_left == 0) begin
      ready_mode    = ready_mode_t'($urandom_range(0, 3));
      mode_left     = $urandom_range(40, 300);
      ready_pattern = 16'($urandom);
    end else begin
      mode_left--;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      case (ready_mode)
        READY_ALWAYS: out_tready <= 1'b1;
        READY_COIN:   out_tready <= 1'($urandom_range(0, 1));
        READY_MOSTLY: out_tready <= ($urandom_range(0, 7) != 0);
        default: begin
          out_tready <= ready_pattern[0];
          ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
        end
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               results_due.size());
      $display("status: fail");
      $finish;
    end
  end

  // Offers one byte, with a random gap at the start of each burst.
  task automatic send_byte(input logic [7:0] b, input logic eop);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = gaps_on ? $urandom_range(0, 5) : 0;
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        in_tdata  <= 8'($urandom);
        in_tlast  <= 1'($urandom);
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= eop;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    depacketize_byte(b, eop);
    bytes_sent++;
  endtask

  // Stops the sender and waits until the block has nothing left in flight.
  task automatic settle_block();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (results_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
    settle_block();
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_config(idx, value);
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] pick_payload_byte();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      3: return 8'h7F;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic fill_payload(input int n);
    for (int i = 0; i < n; i++) payload_bytes.push_back(pick_payload_byte());
  endtask

  // Big-endian bytes of one value into the payload.
  task automatic push_word(input logic [23:0] w, input int nbytes);
    for (int i = nbytes - 1; i >= 0; i--) payload_bytes.push_back(w[8*i +: 8]);
  endtask

  // Sends header plus queued payload; cut > 0 truncates the packet to cut bytes.
  task automatic send_packet(input logic [6:0] pt, input logic [15:0] seq, input int cut);
    logic [7:0] hdr [12];
    int         total;
    for (int i = 0; i < 12; i++) hdr[i] = 8'($urandom);
    hdr[1] = {hdr[1][7], pt};
    hdr[2] = seq[15:8];
    hdr[3] = seq[7:0];
    total = (cut > 0) ? cut : 12 + payload_bytes.size();
    for (int i = 0; i < total; i++) begin
      if (i < 12) send_byte(hdr[i], i == total - 1);
      else send_byte(payload_bytes[i - 12], i == total - 1);
    end
    payload_bytes.delete();
    packets_sent++;
    if (cut == 0) seq_next = seq + 16'd1;
  endtask

  task automatic test_sequence_tracking();
    // header-only packets: in order, duplicate, gap, far jump, wrap, half range both ways
    send_packet(cfg_pt24, 16'h1234, 0);
    send_packet(cfg_pt24, 16'h1235, 0);
    send_packet(cfg_pt24, 16'h1235, 0);
    send_packet(cfg_pt24, 16'h1240, 0);
    send_packet(cfg_pt24, 16'hFFFF, 0);
    send_packet(cfg_pt24, 16'h0000, 0);
    send_packet(cfg_pt24, 16'h8000, 0);
    send_packet(cfg_pt24, 16'h0000, 0);
  endtask

  task automatic test_short_packets();
    send_packet(cfg_pt24, 16'hAAAA, 1);
    send_packet(cfg_pt16, 16'h5555, 11);
  endtask

  task automatic test_payload_formats();
    // reset settings: one channel, trailing partial sample dropped
    push_word(24'h7FFFFF, 3);
    push_word(24'h800000, 3);
    push_word(24'h0000AB, 1);
    send_packet(RST_PT_24BIT, seq_next, 0);
    push_word(24'h007FFF, 2);
    push_word(24'h008000, 2);
    push_word(24'h0000FF, 2);
    send_packet(RST_PT_16BIT, seq_next, 0);
    fill_payload(6);
    send_packet(7'd5, seq_next, 0);
    // second frame incomplete at packet end
    write_reg(REG_CHANNEL_COUNT, 8'd2);
    fill_payload(9);
    send_packet(RST_PT_24BIT, seq_next, 0);
    write_reg(REG_CHANNEL_COUNT, 8'd8);
    write_reg(REG_PT_24BIT, 8'd127);
    write_reg(REG_PT_16BIT, 8'd0);
    fill_payload(24);
    send_packet(7'd127, seq_next, 0);
    fill_payload(17);
    send_packet(7'd0, seq_next, 0);
    // zero channels behaves as one
    write_reg(REG_CHANNEL_COUNT, 8'd0);
    fill_payload(4);
    send_packet(7'd0, seq_next, 0);
    // above the maximum clamps to eight
    write_reg(REG_CHANNEL_COUNT, 8'd15);
    fill_payload(24);
    send_packet(7'd127, seq_next, 0);
    // same number for both formats: 24-bit wins
    write_reg(REG_PT_16BIT, 8'd127);
    fill_payload(6);
    send_packet(7'd127, seq_next, 0);
  endtask

  task automatic test_backpressure();
    // three full frames: one drains, one waits, the third is offered against a stall
    write_reg(REG_CHANNEL_COUNT, 8'd8);
    gaps_on  = 1'b0;
    hold_req = 1'b1;
    fill_payload(3 * 8 * 3);
    send_packet(cfg_pt24, seq_next, 0);
    hold_req = 1'b0;
    settle_block();
    gaps_on = 1'b1;
  endtask

  task automatic randomize_config();
    logic [3:0] ch;
    logic [6:0] pt24;
    logic [6:0] pt16;
    ch   = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(1, FRAME_MAX));
    pt24 = 7'($urandom);
    pt16 = ($urandom_range(0, 7) == 0) ? pt24 : 7'($urandom);
    write_reg(REG_CHANNEL_COUNT, {4'd0, ch});
    write_reg(REG_PT_24BIT, {1'b0, pt24});
    write_reg(REG_PT_16BIT, {1'b0, pt16});
  endtask

  task automatic test_random_traffic();
    int          start_bytes;
    int          pkt;
    int          pick;
    int          width;
    int          len;
    logic [6:0]  pt;
    logic [15:0] seq;
    start_bytes = bytes_sent;
    pkt = 0;
    while (bytes_sent - start_bytes < RANDOM_BYTES) begin
      if (pkt % 4 == 0) randomize_config();
      gaps_on = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 19);
      seq  = seq_next;
      if (pick == 0) seq = 16'($urandom);
      else if (pick == 1) seq = seq_next + 16'($urandom_range(2, 40));
      else if (pick == 2) seq = seq_next - 16'd1;
      if (pick == 3 || pick == 4) begin
        do pt = 7'($urandom); while (pt == cfg_pt24 || pt == cfg_pt16);
        fill_payload($urandom_range(0, 12));
        send_packet(pt, seq, 0);
      end else if (pick == 5 || pick == 6) begin
        send_packet(7'($urandom), seq, $urandom_range(1, 11));
      end else begin
        if ($urandom_range(0, 1) == 1 || cfg_pt16 == cfg_pt24) begin
          pt = cfg_pt24;
          width = 3;
        end else begin
          pt = cfg_pt16;
          width = 2;
        end
        len = $urandom_range(0, 3) * int'(frame_size()) * width;
        if ($urandom_range(0, 3) == 0) len += $urandom_range(1, int'(frame_size()) * width);
        fill_payload(len);
        send_packet(pt, seq, 0);
      end
      pkt++;
    end
  endtask

  initial begin
    reset_predictor();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_sequence_tracking();
    test_short_packets();
    test_payload_formats();
    test_backpressure();
    test_random_traffic();
    settle_block();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (results_due.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", results_due.size()));
    $display("run: %0d bytes in %0d packets, %0d results checked, %0d register writes",
             bytes_sent, packets_sent, results_checked, cfg_writes);
    $display("run: sequence gaps and wraps, short and unknown packets, frame sizes, long stall");
    if (error_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
